// File: rtl/llss_pkg.sv
// package for the least-loaded server selector
// opcodes, status codes, field widths and the stored entry layout; no dependencies
`timescale 1ns / 1ps

package llss_pkg;

    localparam int OP_W     = 3;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 16;
    localparam int SEQ_W    = 64;
    localparam int CAP_W    = 16;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CHOOSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
    localparam logic [OP_W-1:0] OP_HEALTH   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNAVAILABLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_EXIST   = 3'd4;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // one server entry as held in the table memory; the valid bit lives in flops
    typedef struct packed {
        logic             live;
        logic             last_ok;
        logic [OUT_W-1:0] outstanding;
        logic [SEQ_W-1:0] last_seq;
    } t_entry;

endpackage

// File: rtl/llss_ram.sv
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module llss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/least_loaded_server_selector.sv
// least-loaded server selector, top level
// uses llss_pkg and llss_ram (entry table)
`timescale 1ns / 1ps

// Picks a server entry for each request and tracks per-entry load.
// Input stream: one beat per command (add, remove, choose, complete, health ok).
// Output stream: exactly one beat per command, carrying status and chosen index.
// The per-server load limit is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, as the block does not enforce it. Commands run one
// at a time. Add, remove, complete, health ok and unknown opcodes pass through the
// execute and done states; choose passes through the scan, final and done states,
// the scan reading one table entry a cycle from the entry memory and comparing it
// against the best live and best unlive candidate so far. Entry state other than
// the valid bit sits in one memory with registered read data; updates are
// read-modify-write with one command in flight, so no entry access overlaps another.
// Reset clears all valid bits, the dispatch sequence and the load limit; the
// block takes a beat in the first cycle after reset.
// A finished result waits in the output register; while it is not taken, the
// next command is still accepted and worked on, and stalls only when its own
// result is ready and the output register is still full.

module least_loaded_server_selector #(
    parameter int NUM_SERVERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] opcode, [6:3] entry_index, [7] failed
    input  logic [7:0]  i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] status, [6:3] chosen_index, [7] zero
    output logic [7:0]  o_m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int IW = $clog2(NUM_SERVERS);
    localparam int EW = $bits(llss_pkg::t_entry);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SERVERS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // input fields
    logic [llss_pkg::OP_W-1:0]  w_op;
    logic [llss_pkg::IDX_W-1:0] w_idx;
    logic                       w_failed;
    logic                       w_accept;

    assign w_op     = i_s_axis_tdata[2:0];
    assign w_idx    = i_s_axis_tdata[6:3];
    assign w_failed = i_s_axis_tdata[7];

    // control state
    logic [2:0]                  r_state;
    logic [NUM_SERVERS-1:0]      r_valid;
    logic [llss_pkg::SEQ_W-1:0]  r_seq;
    logic [llss_pkg::CAP_W-1:0]  r_cap;
    logic                        r_out_valid;

    // command held while it runs
    logic [llss_pkg::OP_W-1:0]   r_op;
    logic [IW-1:0]               r_idx;
    logic                        r_in_table;
    logic                        r_failed;
    logic [IW-1:0]               r_cnt;

    // scan candidates
    logic                        r_lhave;
    logic [IW-1:0]               r_lidx;
    logic                        r_lok;
    logic [llss_pkg::OUT_W-1:0]  r_lout;
    logic [llss_pkg::SEQ_W-1:0]  r_lseq;
    logic                        r_uhave;
    logic [IW-1:0]               r_uidx;
    logic                        r_uok;
    logic [llss_pkg::OUT_W-1:0]  r_uout;
    logic [llss_pkg::SEQ_W-1:0]  r_useq;

    // pending result and output register
    logic [llss_pkg::STATUS_W-1:0] r_res_status;
    logic [llss_pkg::IDX_W-1:0]    r_res_chosen;
    logic [llss_pkg::STATUS_W-1:0] r_out_status;
    logic [llss_pkg::IDX_W-1:0]    r_out_chosen;

    // memory ports
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    llss_pkg::t_entry     w_wr_entry;
    logic [IW-1:0]        w_rd_addr;
    logic [EW-1:0]        w_rd_raw;
    llss_pkg::t_entry     w_rd_entry;

    logic                 w_slot_free;
    logic                 w_cand_valid;
    logic                 w_live_better;
    logic                 w_unlive_better;
    logic [llss_pkg::OUT_W-1:0] w_out_dec;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_rd_entry  = llss_pkg::t_entry'(w_rd_raw);

    llss_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SERVERS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (EW'(w_wr_entry)),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    // read address: the addressed entry at accept, entry 0 to start a scan
    always_comb begin
        w_rd_addr = r_cnt + IW'(1);
        if (r_state == S_IDLE) begin
            w_rd_addr = (w_op == llss_pkg::OP_CHOOSE) ? '0 : IW'(w_idx);
        end
    end

    // scan compare for the entry whose data is on the read port
    assign w_cand_valid    = r_valid[r_cnt];
    assign w_live_better   = w_cand_valid && w_rd_entry.live &&
                             (!r_lhave ||
                              ({w_rd_entry.outstanding, w_rd_entry.last_seq} <
                               {r_lout, r_lseq}));
    // last_ok entries first, then oldest sequence
    assign w_unlive_better = w_cand_valid && !w_rd_entry.live &&
                             (!r_uhave ||
                              ({!w_rd_entry.last_ok, w_rd_entry.last_seq} <
                               {!r_uok, r_useq}));

    assign w_out_dec = (w_rd_entry.outstanding == '0) ? w_rd_entry.outstanding
                                                      : w_rd_entry.outstanding -
                                                        llss_pkg::OUT_W'(1);

    // write-back and result of the command
    logic [llss_pkg::STATUS_W-1:0] w_status;
    logic [llss_pkg::IDX_W-1:0]    w_chosen;
    logic                          w_set_valid;
    logic                          w_clr_valid;
    logic                          w_bump_seq;

    always_comb begin
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_entry  = w_rd_entry;
        w_status    = llss_pkg::ST_OK;
        w_chosen    = '0;
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        w_bump_seq  = 1'b0;
        if (r_state == S_EXEC) begin
            case (r_op)
                llss_pkg::OP_ADD: begin
                    if (!r_in_table) begin
                        w_status = llss_pkg::ST_NOT_EXIST;
                    end else if (r_valid[r_idx]) begin
                        w_status = llss_pkg::ST_ALREADY;
                    end else begin
                        w_wr_en                = 1'b1;
                        w_wr_entry.live        = 1'b1;
                        w_wr_entry.last_ok     = 1'b1;
                        w_wr_entry.outstanding = '0;
                        w_wr_entry.last_seq    = '0;
                        w_set_valid            = 1'b1;
                    end
                end
                llss_pkg::OP_REMOVE: begin
                    // live is rewritten by the next add, so only valid drops
                    if (!r_in_table || !r_valid[r_idx]) begin
                        w_status = llss_pkg::ST_NOT_EXIST;
                    end else begin
                        w_clr_valid = 1'b1;
                    end
                end
                llss_pkg::OP_COMPLETE: begin
                    if (!r_in_table || !r_valid[r_idx]) begin
                        w_status = llss_pkg::ST_NOT_EXIST;
                    end else begin
                        w_wr_en                = 1'b1;
                        w_wr_entry.outstanding = w_out_dec;
                        w_wr_entry.last_ok     = !r_failed;
                        if (r_failed) begin
                            w_wr_entry.live = 1'b0;
                        end
                    end
                end
                llss_pkg::OP_HEALTH: begin
                    if (!r_in_table || !r_valid[r_idx]) begin
                        w_status = llss_pkg::ST_NOT_EXIST;
                    end else begin
                        w_wr_en         = 1'b1;
                        w_wr_entry.live = 1'b1;
                    end
                end
                default: begin
                    w_status = llss_pkg::ST_OK;
                end
            endcase
        end else if (r_state == S_FINAL) begin
            if (r_lhave) begin
                if (r_cap != '0 && r_lout >= r_cap) begin
                    w_status = llss_pkg::ST_BUSY;
                end else begin
                    w_wr_en    = 1'b1;
                    w_wr_addr  = r_lidx;
                    w_wr_entry = '{live: 1'b1, last_ok: r_lok,
                                   outstanding: (r_lout == llss_pkg::OUT_MAX) ? r_lout :
                                                r_lout + llss_pkg::OUT_W'(1),
                                   last_seq: r_seq + llss_pkg::SEQ_W'(1)};
                    w_chosen   = llss_pkg::IDX_W'(r_lidx);
                    w_bump_seq = 1'b1;
                end
            end else if (r_uhave) begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_uidx;
                w_wr_entry = '{live: 1'b0, last_ok: r_uok,
                               outstanding: (r_uout == llss_pkg::OUT_MAX) ? r_uout :
                                            r_uout + llss_pkg::OUT_W'(1),
                               last_seq: r_seq + llss_pkg::SEQ_W'(1)};
                w_chosen   = llss_pkg::IDX_W'(r_uidx);
                w_bump_seq = 1'b1;
            end else begin
                w_status = llss_pkg::ST_UNAVAILABLE;
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // sequencer and control state
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_op == llss_pkg::OP_CHOOSE) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_FINAL;
                end
            end
            S_EXEC:  n_state = S_DONE;
            S_FINAL: n_state = S_DONE;
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_seq       <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
            r_lhave     <= 1'b0;
            r_uhave     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_set_valid) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (w_clr_valid) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (w_bump_seq) begin
                r_seq <= r_seq + llss_pkg::SEQ_W'(1);
            end
            if (r_state == S_IDLE && w_accept) begin
                r_lhave <= 1'b0;
                r_uhave <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                if (w_live_better) begin
                    r_lhave <= 1'b1;
                end
                if (w_unlive_better) begin
                    r_uhave <= 1'b1;
                end
            end
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_op       <= w_op;
            r_idx      <= IW'(w_idx);
            r_in_table <= (int'(w_idx) < NUM_SERVERS);
            r_failed   <= w_failed;
            r_cnt      <= '0;
        end
        if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + IW'(1);
            if (w_live_better) begin
                r_lidx <= r_cnt;
                r_lok  <= w_rd_entry.last_ok;
                r_lout <= w_rd_entry.outstanding;
                r_lseq <= w_rd_entry.last_seq;
            end
            if (w_unlive_better) begin
                r_uidx <= r_cnt;
                r_uok  <= w_rd_entry.last_ok;
                r_uout <= w_rd_entry.outstanding;
                r_useq <= w_rd_entry.last_seq;
            end
        end
        if (r_state == S_EXEC || r_state == S_FINAL) begin
            r_res_status <= w_status;
            r_res_chosen <= w_chosen;
        end
        if (r_state == S_DONE && w_slot_free) begin
            r_out_status <= r_res_status;
            r_out_chosen <= r_res_chosen;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_chosen, r_out_status};

endmodule

// File: tb/testbench.sv
// testbench for least_loaded_server_selector: directed and random command beats,
// each reply checked against a behavioural model of the server entry table
// depends on llss_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_ENTRIES = 16;
    localparam logic [llss_pkg::OP_W-1:0] OP_SPARE_LO = llss_pkg::OP_HEALTH + 1'b1;

    typedef struct packed {
        logic [llss_pkg::STATUS_W-1:0] status;
        logic [llss_pkg::IDX_W-1:0]    chosen;
    } t_reply;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       cmd_valid   = 1'b0;
    logic [7:0]                 cmd_data    = '0;
    logic                       reply_ready = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [llss_pkg::CAP_W-1:0] cfg_wr_data = '0;
    logic                       cmd_ready;
    logic                       reply_valid;
    logic [7:0]                 reply_data;

    // model of the entry table
    logic                       tbl_valid       [NUM_ENTRIES];
    logic                       tbl_live        [NUM_ENTRIES];
    logic                       tbl_last_ok     [NUM_ENTRIES];
    logic [llss_pkg::OUT_W-1:0] tbl_outstanding [NUM_ENTRIES];
    logic [llss_pkg::SEQ_W-1:0] tbl_last_seq    [NUM_ENTRIES];
    logic [llss_pkg::SEQ_W-1:0] dispatch_count;
    logic [llss_pkg::CAP_W-1:0] load_limit;

    t_reply reply_queue[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     fail_count    = 0;

    least_loaded_server_selector #(
        .NUM_SERVERS(NUM_ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .o_m_axis_tvalid (reply_valid),
        .i_m_axis_tready (reply_ready),
        .o_m_axis_tdata  (reply_data),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // works out the reply to one command and updates the table model
    function automatic t_reply predict_reply(input logic [llss_pkg::OP_W-1:0] op,
                                             input logic [llss_pkg::IDX_W-1:0] idx,
                                             input logic failed);
        t_reply reply;
        logic   have;
        int     best;
        reply.status = llss_pkg::ST_OK;
        reply.chosen = '0;
        have = 1'b0;
        best = 0;
        case (op)
            llss_pkg::OP_ADD: begin
                if (tbl_valid[idx]) begin
                    reply.status = llss_pkg::ST_ALREADY;
                end else begin
                    tbl_valid[idx]       = 1'b1;
                    tbl_live[idx]        = 1'b1;
                    tbl_last_ok[idx]     = 1'b1;
                    tbl_outstanding[idx] = '0;
                    tbl_last_seq[idx]    = '0;
                end
            end
            llss_pkg::OP_REMOVE: begin
                if (!tbl_valid[idx]) begin
                    reply.status = llss_pkg::ST_NOT_EXIST;
                end else begin
                    tbl_valid[idx] = 1'b0;
                    tbl_live[idx]  = 1'b0;
                end
            end
            llss_pkg::OP_CHOOSE: begin
                // least (outstanding, last sequence) among live entries, lowest index on ties
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_live[i] &&
                        (!have || tbl_outstanding[i] < tbl_outstanding[best] ||
                         (tbl_outstanding[i] == tbl_outstanding[best] &&
                          tbl_last_seq[i] < tbl_last_seq[best]))) begin
                        best = i;
                        have = 1'b1;
                    end
                end
                if (have) begin
                    if (load_limit != '0 && tbl_outstanding[best] >= load_limit) begin
                        reply.status = llss_pkg::ST_BUSY;
                    end
                end else begin
                    // fall back to unlive entries, last-succeeded ones first
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (tbl_valid[i] && !tbl_live[i] &&
                            (!have || (tbl_last_ok[i] && !tbl_last_ok[best]) ||
                             (tbl_last_ok[i] == tbl_last_ok[best] &&
                              tbl_last_seq[i] < tbl_last_seq[best]))) begin
                            best = i;
                            have = 1'b1;
                        end
                    end
                    if (!have) begin
                        reply.status = llss_pkg::ST_UNAVAILABLE;
                    end
                end
                if (reply.status == llss_pkg::ST_OK) begin
                    dispatch_count     = dispatch_count + 1'b1;
                    tbl_last_seq[best] = dispatch_count;
                    if (tbl_outstanding[best] != llss_pkg::OUT_MAX) begin
                        tbl_outstanding[best] = tbl_outstanding[best] + 1'b1;
                    end
                    reply.chosen = llss_pkg::IDX_W'(best);
                end
            end
            llss_pkg::OP_COMPLETE: begin
                if (!tbl_valid[idx]) begin
                    reply.status = llss_pkg::ST_NOT_EXIST;
                end else begin
                    if (tbl_outstanding[idx] != '0) begin
                        tbl_outstanding[idx] = tbl_outstanding[idx] - 1'b1;
                    end
                    tbl_last_ok[idx] = !failed;
                    if (failed) begin
                        tbl_live[idx] = 1'b0;
                    end
                end
            end
            llss_pkg::OP_HEALTH: begin
                if (!tbl_valid[idx]) begin
                    reply.status = llss_pkg::ST_NOT_EXIST;
                end else begin
                    tbl_live[idx] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // one command beat; entered and left at a falling edge, valid left high on exit
    task automatic send_cmd(input logic [llss_pkg::OP_W-1:0] op,
                            input logic [llss_pkg::IDX_W-1:0] idx,
                            input logic failed);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= {failed, idx, op};
        do @(posedge i_clk); while (!cmd_ready);
        reply_queue.push_back(predict_reply(op, idx, failed));
        @(negedge i_clk);
    endtask

    task automatic wait_replies;
        cmd_valid <= 1'b0;
        while (reply_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_capacity(input logic [llss_pkg::CAP_W-1:0] value);
        wait_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        load_limit = value;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        reply_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && reply_valid && reply_ready) begin
            if (reply_queue.size() == 0) begin
                note_failure($sformatf("reply beat %h with nothing outstanding", reply_data));
            end else begin
                want = reply_queue.pop_front();
                if (reply_data[2:0] !== want.status || reply_data[6:3] !== want.chosen) begin
                    note_failure($sformatf(
                        "reply mismatch: status exp %0d got %0d, index exp %0d got %0d",
                        want.status, reply_data[2:0], want.chosen, reply_data[6:3]));
                end
            end
        end
    end

    // nothing added yet: every addressed opcode misses and choose finds nothing
    task automatic test_empty_table;
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_REMOVE, 4'd5, 1'b0);
        send_cmd(llss_pkg::OP_COMPLETE, 4'd5, 1'b1);
        send_cmd(llss_pkg::OP_HEALTH, 4'd5, 1'b0);
        send_cmd(OP_SPARE_LO, 4'd15, 1'b1);
        send_cmd('1, 4'd10, 1'b0);
    endtask

    task automatic test_live_choice;
        send_cmd(llss_pkg::OP_ADD, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_ADD, 4'd0, 1'b1);
        send_cmd(llss_pkg::OP_ADD, 4'd15, 1'b0);
        // equal load goes to the lower index, then the older dispatch
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_COMPLETE, 4'd15, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
    endtask

    task automatic test_fallback_choice;
        send_cmd(llss_pkg::OP_COMPLETE, 4'd0, 1'b1);
        send_cmd(llss_pkg::OP_COMPLETE, 4'd15, 1'b1);
        // success on an unlive entry sets last-ok but leaves it unlive
        send_cmd(llss_pkg::OP_COMPLETE, 4'd15, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_HEALTH, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_REMOVE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_REMOVE, 4'd15, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
    endtask

    task automatic test_capacity_limit;
        set_capacity(16'd1);
        send_cmd(llss_pkg::OP_ADD, 4'd2, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
        set_capacity('1);
        send_cmd(llss_pkg::OP_CHOOSE, 4'd0, 1'b0);
    endtask

    // blocks of 64 commands, each with a fresh capacity and an index pool of 2, 4, 8 or 16 entries
    task automatic test_random_traffic(input int blocks);
        int                         r;
        logic [llss_pkg::IDX_W-1:0] idx_limit;
        logic [llss_pkg::OP_W-1:0]  op;
        logic [llss_pkg::CAP_W-1:0] cap;
        repeat (blocks) begin
            case ($urandom_range(5))
                0: cap = '0;
                1: cap = 16'd1;
                2: cap = 16'd2;
                3: cap = 16'd3;
                4: cap = llss_pkg::CAP_W'($urandom_range(12, 4));
                default: cap = '1;
            endcase
            set_capacity(cap);
            // small pools make an all-unlive table and busy answers common
            idx_limit = llss_pkg::IDX_W'((1 << $urandom_range(4, 1)) - 1);
            repeat (64) begin
                r = $urandom_range(99);
                if (r < 14) begin
                    op = llss_pkg::OP_ADD;
                end else if (r < 22) begin
                    op = llss_pkg::OP_REMOVE;
                end else if (r < 55) begin
                    op = llss_pkg::OP_CHOOSE;
                end else if (r < 80) begin
                    op = llss_pkg::OP_COMPLETE;
                end else if (r < 95) begin
                    op = llss_pkg::OP_HEALTH;
                end else begin
                    op = OP_SPARE_LO + llss_pkg::OP_W'($urandom_range(2));
                end
                send_cmd(op, llss_pkg::IDX_W'($urandom_range(idx_limit)),
                         ($urandom_range(99) < 35));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            tbl_valid[i]       = 1'b0;
            tbl_live[i]        = 1'b0;
            tbl_last_ok[i]     = 1'b0;
            tbl_outstanding[i] = '0;
            tbl_last_seq[i]    = '0;
        end
        dispatch_count = '0;
        load_limit     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 78;
        test_empty_table();
        test_live_choice();
        test_fallback_choice();
        test_capacity_limit();
        test_random_traffic(5);

        send_idle_pct = 78;
        recv_idle_pct = 36;
        test_random_traffic(5);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(6);

        wait_replies();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/llss_pkg.sv
rtl/llss_ram.sv
rtl/least_loaded_server_selector.sv
tb/testbench.sv
